FILE: rtl/core/message_header_filter_table_unit_macros.svh
// Assertion macros shared by the filter table RTL
`ifndef MESSAGE_HEADER_FILTER_TABLE_UNIT_MACROS_SVH
`define MESSAGE_HEADER_FILTER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define MHFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MHFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mhft_pkg.sv
// Package: sizes, command and status codes, RAM request type for the filter table
`timescale 1ns / 1ps
package mhft_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W    = 16;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
    } t_ram_req;

    function automatic logic [OCNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+OCNT_W-1:0] t;
        t = (CNT_W + OCNT_W)'(c);
        return t[OCNT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/message_header_filter_table_unit.sv
// Top level: message key filter table with a sequential scan over a key RAM
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_cmd, i_msg_key
//  out     | output    | o_out_valid / i_out_ready  | o_key_found, o_status, o_entry_count
//
// One item at a time; the scan reads each stored entry through the RAM read port (S_READ)
// and compares it with the key (S_CMP) until a match or the end of the table, then goes
// through S_APPLY, S_MOVE for a remove that moves the last entry, and S_DONE.
// Reset clears the count and control; the key RAM is not cleared.
// A finished result waits in the output register; the block stalls only if the next
// result is ready before the previous one is taken.
`timescale 1ns / 1ps
`include "message_header_filter_table_unit_macros.svh"
module message_header_filter_table_unit
    import mhft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [KEY_W-1:0]  i_msg_key,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_key_found,
    output logic [STAT_W-1:0] o_status,
    output logic [OCNT_W-1:0] o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_APPLY,
        S_MOVE,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_slot;
    logic                r_found;
    logic [STAT_W-1:0]   r_status;
    logic                r_out_valid;
    logic                r_out_found;
    logic [STAT_W-1:0]   r_out_status;
    logic [OCNT_W-1:0]   r_out_count;

    t_ram_req            ram_req;
    logic [KEY_W-1:0]    rd_data;
    logic [CNT_W-1:0]    last;
    logic                in_xfer;

    assign last    = r_count - CNT_W'(1);
    assign in_xfer = i_in_valid && o_in_ready;

    always_comb begin
        ram_req       = '0;
        ram_req.wdata = r_key;
        unique case (r_state)
            S_READ: begin
                ram_req.re    = (r_idx != r_count);
                ram_req.raddr = r_idx[IDX_W-1:0];
            end
            S_APPLY: begin
                if (r_cmd == CMD_ADD) begin
                    ram_req.we    = (r_count < CNT_W'(CAPACITY));
                    ram_req.waddr = r_count[IDX_W-1:0];
                end else if (r_cmd == CMD_REMOVE) begin
                    ram_req.re    = r_found;
                    ram_req.raddr = last[IDX_W-1:0];
                end
            end
            S_MOVE: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_slot;
                ram_req.wdata = rd_data;
            end
            default: ram_req = ram_req;
        endcase
    end

    mhft_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_cmd;
                        r_key   <= i_msg_key;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= (r_idx == r_count) ? S_APPLY : S_CMP;
                end
                S_CMP: begin
                    if (rd_data == r_key) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx[IDX_W-1:0];
                        r_state <= S_APPLY;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_APPLY: begin
                    case (r_cmd)
                        CMD_ADD: begin
                            r_state <= S_DONE;
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_OK;
                                r_count  <= r_count + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (!r_found) begin
                                r_status <= ST_ABSENT;
                                r_state  <= S_DONE;
                            end else if (CNT_W'(r_slot) == last) begin
                                r_status <= ST_OK;
                                r_count  <= last;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_MOVE;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_MOVE: begin
                    r_count <= last;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_found  <= r_found;
                        r_out_status <= r_status;
                        r_out_count  <= to_entry_count(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_key_found   = r_out_found;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    `MHFT_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "count over capacity")
    `MHFT_ASSERT_NOW(a_full_count, i_clk, i_rst_n, r_state == S_DONE && r_status == ST_FULL, r_count == CNT_W'(CAPACITY), "full with room")
    `MHFT_ASSERT_NOW(a_absent_nf, i_clk, i_rst_n, o_out_valid && o_status == ST_ABSENT, !o_key_found, "absent status with key found")
    `MHFT_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, in_xfer, r_state == S_READ, "scan not started after transfer")

endmodule

FILE: rtl/core/mhft_ram.sv
// Key store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module mhft_ram
    import mhft_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
